[rtl/core/aps_pkg.sv]
package aps_pkg;

  localparam int MAX_VERTICES = 16;
  localparam int COST_WIDTH   = 16;

  localparam int VW        = $clog2(MAX_VERTICES);
  localparam int AW        = 2 * VW;
  localparam int MEM_DEPTH = 1 << AW;
  // extended width: holds any sum of two costs and the 15-bit infinity
  localparam int EW        = ((COST_WIDTH > 16) ? COST_WIDTH : 16) + 2;
  localparam int PADDR_W   = 3;

  // request actions
  localparam logic [1:0] ACT_WRITE = 2'd0;
  localparam logic [1:0] ACT_RUN   = 2'd1;
  localparam logic [1:0] ACT_READ  = 2'd2;

  // result status codes
  localparam logic [1:0] ST_READ    = 2'd0;
  localparam logic [1:0] ST_CLEAN   = 2'd1;
  localparam logic [1:0] ST_CIRCUIT = 2'd2;

  // register indexes (paddr[2])
  localparam logic REG_VCOUNT = 1'b0;
  localparam logic REG_INF    = 1'b1;

  typedef logic [VW-1:0]                vidx_t;
  typedef logic [AW-1:0]                addr_t;
  typedef logic signed [COST_WIDTH-1:0] cost_t;
  typedef logic signed [EW-1:0]         ext_t;

  typedef struct packed {
    logic [1:0]         action;
    logic [3:0]         row;
    logic [3:0]         col;
    logic signed [15:0] cost;
  } req_t;

  typedef struct packed {
    logic [1:0]         status;
    logic [3:0]         vertex_a;
    logic [3:0]         vertex_b;
    logic signed [15:0] value;
  } rsp_t;

  typedef struct packed {
    logic [4:0]  vertex_count;
    logic [14:0] infinity_cost;
  } cfg_t;

  localparam ext_t CMAX_E  = ext_t'((64'sd1 <<< (COST_WIDTH - 1)) - 64'sd1);
  localparam ext_t CMIN_E  = -CMAX_E - ext_t'(1);
  localparam ext_t OUT_MAX = ext_t'(32767);
  localparam ext_t OUT_MIN = ext_t'(-32768);

  function automatic ext_t ext(cost_t v);
    return ext_t'(v);
  endfunction

  function automatic cost_t clamp_cost(ext_t v);
    ext_t w;
    w = v;
    if (v > CMAX_E) w = CMAX_E;
    else if (v < CMIN_E) w = CMIN_E;
    return cost_t'(w);
  endfunction

  function automatic cost_t write_cost(logic signed [15:0] c);
    return clamp_cost(ext_t'(c));
  endfunction

  function automatic logic signed [15:0] clamp_read(cost_t v);
    ext_t w;
    w = ext(v);
    if (w > OUT_MAX) w = OUT_MAX;
    else if (w < OUT_MIN) w = OUT_MIN;
    return w[15:0];
  endfunction

  // saturating add; infinity absorbs
  function automatic cost_t sat_add(cost_t a, cost_t b, logic [14:0] inf);
    ext_t  infv;
    ext_t  s;
    cost_t infc;
    infv = ext_t'({1'b0, inf});
    infc = clamp_cost(infv);
    if (ext(a) >= infv || ext(b) >= infv) return infc;
    s = ext(clamp_cost(ext(a) + ext(b)));
    if (s >= infv) return infc;
    return cost_t'(s);
  endfunction

  function automatic addr_t mk_addr(vidx_t r, vidx_t c);
    return {r, c};
  endfunction

endpackage

[rtl/core/aps_cfg.sv]
module aps_cfg import aps_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  output cfg_t               cfg
);

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.vertex_count  <= 5'd16;
      cfg.infinity_cost <= 15'h7fff;
    end else if (psel && penable && pwrite) begin
      case (paddr[2])
        REG_VCOUNT: cfg.vertex_count  <= pwdata[4:0];
        REG_INF:    cfg.infinity_cost <= pwdata[14:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_VCOUNT: prdata = {27'd0, cfg.vertex_count};
      REG_INF:    prdata = {17'd0, cfg.infinity_cost};
      default:    prdata = '0;
    endcase
  end

endmodule

[rtl/core/aps_engine.sv]
module aps_engine import aps_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  cfg_t cfg,
  input  logic start,
  input  req_t req,
  output logic busy,
  output logic done,
  output rsp_t result
);

  typedef enum logic [2:0] {
    S_IDLE, S_READ, S_INIT, S_AB, S_T, S_CMP, S_CHKRD, S_CHK
  } state_t;

  // PH_IN: relax i->m, PH_OUT: relax m->i, PH_PAIR: relax i->j through m
  typedef enum logic [1:0] {PH_IN, PH_OUT, PH_PAIR} phase_t;

  state_t state;
  phase_t phase;
  vidx_t  m, i, j;
  cost_t  sum;
  logic   rd_ok;

  // matrix store: one write port, two registered read ports
  cost_t mem [MEM_DEPTH];
  addr_t raddr0, raddr1, waddr;
  cost_t rdata0, rdata1, wdata;
  logic  we;

  logic  accept, host_ok, last_j, last_i, last_m, too_few;
  vidx_t host_r, host_c, mlast;
  addr_t host_addr, addr_a, addr_b, addr_t_;
  cost_t chk_sum;

  assign accept    = start && (state == S_IDLE);
  assign busy      = (state != S_IDLE);
  assign host_ok   = (int'(req.row) < MAX_VERTICES) && (int'(req.col) < MAX_VERTICES);
  assign host_r    = vidx_t'(req.row);
  assign host_c    = vidx_t'(req.col);
  assign host_addr = mk_addr(host_r, host_c);

  assign too_few = (cfg.vertex_count < 5'd2);
  assign mlast   = (int'(cfg.vertex_count) > MAX_VERTICES) ? vidx_t'(MAX_VERTICES - 1)
                                                         : vidx_t'(cfg.vertex_count - 5'd1);

  assign last_j = (j == m - vidx_t'(1));
  assign last_i = (i == m - vidx_t'(1));
  assign last_m = (m == mlast);

  assign chk_sum = sat_add(rdata0, rdata1, cfg.infinity_cost);

  always_comb begin
    case (phase)
      PH_IN: begin
        addr_a  = mk_addr(i, j);
        addr_b  = mk_addr(j, m);
        addr_t_ = mk_addr(i, m);
      end
      PH_OUT: begin
        addr_a  = mk_addr(m, j);
        addr_b  = mk_addr(j, i);
        addr_t_ = mk_addr(m, i);
      end
      PH_PAIR: begin
        addr_a  = mk_addr(i, m);
        addr_b  = mk_addr(m, j);
        addr_t_ = mk_addr(i, j);
      end
      default: begin
        addr_a  = '0;
        addr_b  = '0;
        addr_t_ = '0;
      end
    endcase
  end

  always_comb begin
    case (state)
      S_IDLE: begin
        raddr0 = host_addr;
        raddr1 = '0;
      end
      S_AB: begin
        raddr0 = addr_a;
        raddr1 = addr_b;
      end
      S_T: begin
        raddr0 = addr_t_;
        raddr1 = '0;
      end
      S_CHKRD: begin
        raddr0 = mk_addr(i, m);
        raddr1 = mk_addr(m, i);
      end
      default: begin
        raddr0 = '0;
        raddr1 = '0;
      end
    endcase
  end

  // a relaxation writes back in S_CMP; the next read issues in the cycle after,
  // so no read ever overlaps a pending write of the same entry
  always_comb begin
    if (state == S_CMP) begin
      we    = (sum < rdata0);
      waddr = addr_t_;
      wdata = sum;
    end else begin
      we    = accept && (req.action == ACT_WRITE) && host_ok;
      waddr = host_addr;
      wdata = write_cost(req.cost);
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata0 <= mem[raddr0];
    rdata1 <= mem[raddr1];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        S_IDLE: begin
          if (accept) begin
            case (req.action)
              ACT_READ: begin
                rd_ok <= host_ok;
                state <= S_READ;
              end
              ACT_RUN: state <= S_INIT;
              default: ;
            endcase
          end
        end
        S_READ: begin
          result.status   <= ST_READ;
          result.vertex_a <= '0;
          result.vertex_b <= '0;
          result.value    <= rd_ok ? clamp_read(rdata0) : 16'sd0;
          done            <= 1'b1;
          state           <= S_IDLE;
        end
        S_INIT: begin
          if (too_few) begin
            result.status   <= ST_CLEAN;
            result.vertex_a <= '0;
            result.vertex_b <= '0;
            result.value    <= '0;
            done            <= 1'b1;
            state           <= S_IDLE;
          end else begin
            m     <= vidx_t'(1);
            i     <= '0;
            j     <= '0;
            phase <= PH_IN;
            state <= S_AB;
          end
        end
        S_AB: state <= S_T;
        S_T: begin
          sum   <= sat_add(rdata0, rdata1, cfg.infinity_cost);
          state <= S_CMP;
        end
        S_CMP: begin
          state <= S_AB;
          j     <= j + vidx_t'(1);
          case (phase)
            PH_IN: begin
              if (last_j) begin
                j     <= '0;
                phase <= PH_OUT;
              end
            end
            PH_OUT: begin
              if (last_j) state <= S_CHKRD;
            end
            PH_PAIR: begin
              if (last_j) begin
                j <= '0;
                i <= i + vidx_t'(1);
                if (last_i) begin
                  i     <= '0;
                  m     <= m + vidx_t'(1);
                  phase <= PH_IN;
                  if (last_m) begin
                    result.status   <= ST_CLEAN;
                    result.vertex_a <= '0;
                    result.vertex_b <= '0;
                    result.value    <= '0;
                    done            <= 1'b1;
                    state           <= S_IDLE;
                  end
                end
              end
            end
            default: state <= S_IDLE;
          endcase
        end
        S_CHKRD: state <= S_CHK;
        S_CHK: begin
          if (chk_sum < 0) begin
            result.status   <= ST_CIRCUIT;
            result.vertex_a <= 4'(i);
            result.vertex_b <= 4'(m);
            result.value    <= '0;
            done            <= 1'b1;
            state           <= S_IDLE;
          end else begin
            j     <= '0;
            state <= S_AB;
            if (last_i) begin
              i     <= '0;
              phase <= PH_PAIR;
            end else begin
              i     <= i + vidx_t'(1);
              phase <= PH_IN;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

[rtl/core/all_pairs_shortest_paths_top.sv]
// Channel   Ports                                  Handshake
// -------   -------------------------------------  ----------------------------------
// request   start, busy, req                       taken when start && !busy
// result    done, result                           done marks one cycle, no backpressure
// config    psel, penable, pwrite, paddr, pwdata,  write at psel && penable && pwrite,
//           prdata, pready                         pready tied high
//
// A write request leaves busy low; a read passes through S_READ (busy there)
// and strobes its result as the engine returns to idle.
// A run is set by the matrix memory's two read ports: each relaxation steps
// through read pair, read target and compare/write back, each circuit check
// through a read of the loop pair and the check itself.
// A run stopped by a negative circuit ends earlier.
// rst is synchronous and clears the engine state, done and the config registers;
// the matrix holds no reset and reads undefined until written. The receiver cannot stall.
module all_pairs_shortest_paths_top import aps_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  // request / result
  input  logic               start,
  input  req_t               req,
  output logic               busy,
  output logic               done,
  output rsp_t               result,
  // configuration
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  cfg_t cfg;

  // vertex_count at 0x0, infinity_cost at 0x4
  aps_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // matrix memory plus the read-modify-write sequencer for the run
  aps_engine u_eng (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg),
    .start  (start),
    .req    (req),
    .busy   (busy),
    .done   (done),
    .result (result)
  );

endmodule

[rtl/core/aps_checker.sv]
module aps_checker import aps_pkg::*; (
  input logic clk,
  input logic rst,
  input logic start,
  input logic busy,
  input req_t req,
  input logic done,
  input rsp_t result
);

  // nothing finishes in the cycle right after a request is taken
  a_no_early_done: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> !done)
    else $error("result strobed right after a request");

  a_read_latency: assert property (@(posedge clk) disable iff (rst)
    start && !busy && req.action == ACT_READ |=> busy ##1 (done && result.status == ST_READ))
    else $error("read result not returned on time");

  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy))
    else $error("result without a request in progress");

  a_vertices_zero: assert property (@(posedge clk) disable iff (rst)
    done && result.status != ST_CIRCUIT |-> result.vertex_a == 4'd0 && result.vertex_b == 4'd0)
    else $error("circuit vertices set on a non-circuit result");

  a_value_zero: assert property (@(posedge clk) disable iff (rst)
    done && result.status != ST_READ |-> result.value == 16'sd0)
    else $error("value set on a run result");

endmodule

bind all_pairs_shortest_paths_top aps_checker u_chk (.*);

[tb/apsp_check.sv]
`timescale 1ns / 100ps

module apsp_check import aps_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic               busy,
  input  req_t               req,
  input  logic               done,
  input  rsp_t               result,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic               pready,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [31:0]        pwdata,
  output int                 errors,
  output int                 outstanding
);

  localparam longint COST_HI = (longint'(1) <<< (COST_WIDTH - 1)) - 1;
  localparam longint COST_LO = -COST_HI - 1;

  longint      path_len [MAX_VERTICES*MAX_VERTICES];
  logic [4:0]  vcount_reg;
  logic [14:0] inf_reg;
  rsp_t        expected_rsp [$];
  rsp_t        oldest;

  function automatic longint clip_cost(longint v);
    if (v > COST_HI) return COST_HI;
    if (v < COST_LO) return COST_LO;
    return v;
  endfunction

  function automatic longint cost_at(int r, int c);
    return path_len[r*MAX_VERTICES + c];
  endfunction

  // length of a two-leg path; infinity absorbs, finite sums saturate
  function automatic longint leg_sum(longint a, longint b);
    longint inf_v;
    longint s;
    inf_v = inf_reg;
    if (a >= inf_v || b >= inf_v) return clip_cost(inf_v);
    s = clip_cost(a + b);
    return (s >= inf_v) ? clip_cost(inf_v) : s;
  endfunction

  function automatic void shorten(int r, int c, longint x);
    if (x < path_len[r*MAX_VERTICES + c]) path_len[r*MAX_VERTICES + c] = x;
  endfunction

  // Dantzig: grow the vertex set one at a time; stop on a negative loop i, m
  function automatic bit add_vertices(output logic [3:0] va, output logic [3:0] vb);
    int n, m, i, j;
    n = (vcount_reg > MAX_VERTICES) ? MAX_VERTICES : int'(vcount_reg);
    va = '0;
    vb = '0;
    for (m = 1; m < n; m++) begin
      for (i = 0; i < m; i++) begin
        for (j = 0; j < m; j++) shorten(i, m, leg_sum(cost_at(i, j), cost_at(j, m)));
        for (j = 0; j < m; j++) shorten(m, i, leg_sum(cost_at(m, j), cost_at(j, i)));
        if (leg_sum(cost_at(i, m), cost_at(m, i)) < 0) begin
          va = i[3:0];
          vb = m[3:0];
          return 1'b1;
        end
      end
      for (i = 0; i < m; i++)
        for (j = 0; j < m; j++) shorten(i, j, leg_sum(cost_at(i, m), cost_at(m, j)));
    end
    return 1'b0;
  endfunction

  function automatic void take_request(req_t r);
    rsp_t       rsp;
    bit         in_range;
    bit         circuit;
    int         idx;
    longint     v;
    logic [3:0] va, vb;
    rsp      = '0;
    in_range = (r.row < MAX_VERTICES) && (r.col < MAX_VERTICES);
    idx      = int'(r.row) * MAX_VERTICES + int'(r.col);
    case (r.action)
      ACT_WRITE: begin
        if (in_range) path_len[idx] = clip_cost(longint'(r.cost));
      end
      ACT_RUN: begin
        circuit      = add_vertices(va, vb);
        rsp.status   = circuit ? ST_CIRCUIT : ST_CLEAN;
        rsp.vertex_a = va;
        rsp.vertex_b = vb;
        expected_rsp.push_back(rsp);
      end
      ACT_READ: begin
        rsp.status = ST_READ;
        if (in_range) begin
          v = path_len[idx];
          if (v > 32767) v = 32767;
          if (v < -32768) v = -32768;
          rsp.value = v[15:0];
        end
        expected_rsp.push_back(rsp);
      end
      default: ;
    endcase
  endfunction

  function automatic void check_field(string name, logic [15:0] want, logic [15:0] got);
    if (got !== want) begin
      $display("%0t ERROR %s: expected %0d, actual %0d", $time, name, $signed(want),
               $signed(got));
      errors++;
    end
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      vcount_reg = 5'd16;
      inf_reg    = 15'h7FFF;
      errors     = 0;
      expected_rsp.delete();
    end else begin
      if (done) begin
        if (expected_rsp.size() == 0) begin
          $display("%0t ERROR unrequested result: expected none, actual %h", $time, result);
          errors++;
        end else begin
          oldest = expected_rsp.pop_front();
          check_field("status", oldest.status, result.status);
          check_field("vertex_a", oldest.vertex_a, result.vertex_a);
          check_field("vertex_b", oldest.vertex_b, result.vertex_b);
          check_field("value", oldest.value, result.value);
        end
      end
      if (psel && penable && pwrite && pready) begin
        if (paddr[2] == REG_INF) inf_reg = pwdata[14:0];
        else vcount_reg = pwdata[4:0];
      end
      if (start && !busy) take_request(req);
    end
    outstanding = expected_rsp.size();
  end

endmodule

[tb/tb_top.sv]
`timescale 1ns / 100ps

module tb_top;
  import aps_pkg::*;

  // A full 16-vertex run goes on with nothing moving on any channel;
  // allow several times its length before calling it a hang.
  localparam int STALL_LIMIT = 100000;

  // the one action code the block ignores
  localparam logic [1:0] ACT_UNUSED = 2'd3;

  typedef enum {GRAPH_NONNEG, GRAPH_MIXED, GRAPH_EXTREME} graph_kind_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               start = 1'b0;
  req_t               req = '0;
  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [PADDR_W-1:0] paddr = '0;
  logic [31:0]        pwdata = '0;

  logic               busy;
  logic               done;
  rsp_t               result;
  logic [31:0]        prdata;
  logic               pready;

  int errors;
  int outstanding;
  int stall_cycles;

  // stimulus-side bookkeeping
  bit written [MAX_VERTICES*MAX_VERTICES]; // entries that hold a defined value
  bit no_gaps;                             // back-to-back requests this phase
  int item_count;
  int cur_n;                               // vertices a run will touch
  int cur_inf;

  initial forever #4 clk = ~clk;

  all_pairs_shortest_paths_top dut (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .req     (req),
    .busy    (busy),
    .done    (done),
    .result  (result),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  apsp_check result_check (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .req         (req),
    .done        (done),
    .result      (result),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .pready      (pready),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .errors      (errors),
    .outstanding (outstanding)
  );

  // Hang detector: any accepted request, result or register write resets it.
  always @(posedge clk) begin
    if (rst || (start && !busy) || done || (psel && penable && pwrite)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // One request. Called right after a rising edge. busy is sampled at the
  // falling edge, so the next rising edge is known to take the request or not.
  // start stays high across back-to-back requests.
  task automatic send(input logic [1:0] action, input int r, input int c, input int cost_v);
    req_t nxt;
    int   gap;
    logic taken;
    nxt.action = action;
    nxt.row    = r[3:0];
    nxt.col    = c[3:0];
    nxt.cost   = cost_v[15:0];
    gap = no_gaps ? 0 : $urandom_range(0, 5);
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    req   <= nxt;
    do begin
      @(negedge clk);
      taken = !busy;
      @(posedge clk);
    end while (!taken);
    if (action == ACT_WRITE) written[r*MAX_VERTICES + c] = 1'b1;
    if (action != ACT_UNUSED) item_count++;
  endtask

  // Drop start and wait until every result is back and the block is idle.
  // A trailing write gives no result, so leave a few more cycles for it.
  task automatic settle();
    logic quiet;
    start <= 1'b0;
    do begin
      @(negedge clk);
      quiet = (outstanding == 0) && !busy;
      @(posedge clk);
    end while (!quiet);
    repeat (4) @(posedge clk);
  endtask

  // Setup cycle, access cycle, then an idle cycle so that a following write
  // never lowers and raises psel in the same step.
  task automatic cfg_write(input logic regsel, input logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= PADDR_W'({regsel, 2'b00});
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  // Both registers, only with the block idle. Unused data bits get noise.
  task automatic set_limits(input int vc, input int inf_v);
    logic [31:0] noise;
    settle();
    noise = $urandom;
    cfg_write(REG_VCOUNT, {noise[31:5], vc[4:0]});
    noise = $urandom;
    cfg_write(REG_INF, {noise[31:15], inf_v[14:0]});
    cur_n   = (vc > MAX_VERTICES) ? MAX_VERTICES : vc;
    cur_inf = inf_v;
  endtask

  // Edge cost by graph flavor. Diagonal mostly zero except in the extreme mix.
  function automatic int pick_cost(graph_kind_t kind, int r, int c);
    int pick;
    pick = $urandom_range(0, 99);
    if (r == c && kind != GRAPH_EXTREME && pick < 80) return 0;
    case (kind)
      GRAPH_NONNEG: begin
        if (pick < 25) return $urandom_range(cur_inf, 32767);
        return $urandom_range(0, 200);
      end
      GRAPH_MIXED: begin
        if (pick < 20) return $urandom_range(cur_inf, 32767);
        if (pick < 40) return -int'($urandom_range(1, 300));
        return $urandom_range(0, 300);
      end
      default: begin
        case (pick % 5)
          0:       return -32768;
          1:       return 32767;
          2:       return cur_inf;
          3:       return int'($urandom_range(0, 65535)) - 32768;
          default: return int'($urandom_range(0, 60)) - 20;
        endcase
      end
    endcase
  endfunction

  // Every entry a run touches must be defined. Small graphs are rewritten in
  // full; big ones only fill holes and change a few entries.
  task automatic load_graph(input graph_kind_t kind);
    int r, c;
    for (r = 0; r < cur_n; r++)
      for (c = 0; c < cur_n; c++)
        if (cur_n <= 8 || !written[r*MAX_VERTICES + c] || $urandom_range(0, 19) == 0)
          send(ACT_WRITE, r, c, pick_cost(kind, r, c));
  endtask

  // Reads of defined entries only, mostly inside the active graph, with the
  // odd ignored request mixed in.
  task automatic read_some(input int count);
    int r, c, k;
    for (k = 0; k < count; k++) begin
      if ($urandom_range(0, 9) == 0)
        send(ACT_UNUSED, $urandom_range(0, 15), $urandom_range(0, 15), $urandom);
      if (cur_n >= 1 && $urandom_range(0, 3) != 0) begin
        r = $urandom_range(0, cur_n - 1);
        c = $urandom_range(0, cur_n - 1);
      end else begin
        do begin
          r = $urandom_range(0, 15);
          c = $urandom_range(0, 15);
        end while (!written[r*MAX_VERTICES + c]);
      end
      send(ACT_READ, r, c, $urandom);
    end
  endtask

  // Configure, load, run, read back; sometimes patch a few edges and rerun
  // on the partly updated matrix.
  task automatic graph_phase(input int vc, input int inf_v, input graph_kind_t kind);
    int k, r, c;
    set_limits(vc, inf_v);
    no_gaps = ($urandom_range(0, 3) == 0);
    load_graph(kind);
    send(ACT_RUN, $urandom_range(0, 15), $urandom_range(0, 15), $urandom);
    read_some($urandom_range(2, 5));
    if (cur_n >= 1 && $urandom_range(0, 2) == 0) begin
      for (k = 0; k < 2; k++) begin
        r = $urandom_range(0, cur_n - 1);
        c = $urandom_range(0, cur_n - 1);
        send(ACT_WRITE, r, c, pick_cost(kind, r, c));
      end
      send(ACT_RUN, $urandom_range(0, 15), $urandom_range(0, 15), $urandom);
      read_some($urandom_range(2, 4));
    end
  endtask

  initial begin
    int          vc, inf_v, p;
    graph_kind_t kind;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // ---- directed part ----
    // two vertices, extremes of cost and of the index fields
    item_count = 0;
    no_gaps = 1'b0;
    set_limits(2, 32767);
    send(ACT_WRITE, 0, 0, 0);
    send(ACT_WRITE, 0, 1, -32768);
    send(ACT_WRITE, 1, 0, 5);
    send(ACT_WRITE, 1, 1, 0);
    send(ACT_WRITE, 15, 15, 32767);
    send(ACT_WRITE, 15, 0, -1);
    send(ACT_WRITE, 0, 15, 21845);
    send(ACT_READ, 15, 15, 0);
    send(ACT_READ, 15, 0, 0);
    send(ACT_READ, 0, 15, -1);
    send(ACT_UNUSED, 9, 6, 1234);
    // 0->1->0 is hugely negative: circuit on (0, 1)
    send(ACT_RUN, 0, 0, 0);
    send(ACT_READ, 0, 1, 0);
    // positive loop: clean run
    send(ACT_WRITE, 0, 1, 3);
    send(ACT_RUN, 15, 15, -1);

    // small infinity: 0->1->2 sums to 120, which is held at infinity (100),
    // and a stored 32767 counts as no edge
    set_limits(3, 100);
    send(ACT_WRITE, 0, 1, 60);
    send(ACT_WRITE, 1, 2, 60);
    send(ACT_WRITE, 0, 2, 32767);
    send(ACT_WRITE, 2, 0, 200);
    send(ACT_WRITE, 2, 1, 32767);
    send(ACT_WRITE, 2, 2, 0);
    send(ACT_RUN, 0, 0, 0);
    send(ACT_READ, 0, 2, 0);

    // -20000 + -20000 saturates low; the path 0->2 lands at the minimum
    set_limits(3, 32767);
    send(ACT_WRITE, 0, 1, -20000);
    send(ACT_WRITE, 1, 2, -20000);
    send(ACT_WRITE, 1, 0, 32767);
    send(ACT_WRITE, 2, 0, 32767);
    send(ACT_RUN, 0, 0, 0);
    send(ACT_READ, 0, 2, 0);

    // too few vertices: a run does nothing and reports clean
    set_limits(0, 32767);
    send(ACT_RUN, 0, 0, 0);
    set_limits(1, 0);
    send(ACT_RUN, 0, 0, 0);

    // ---- random part ----
    // mostly small graphs so that runs stay short; the occasional medium one
    while (item_count < 100) begin
      p = $urandom_range(0, 9);
      if (p == 0) vc = $urandom_range(0, 1);
      else if (p == 1) vc = $urandom_range(5, 8);
      else vc = $urandom_range(2, 4);
      p = $urandom_range(0, 9);
      if (p <= 2) inf_v = 32767;
      else if (p == 3) inf_v = 0;
      else if (p <= 6) inf_v = $urandom_range(30, 400);
      else inf_v = $urandom_range(0, 32767);
      p = $urandom_range(0, 2);
      kind = (p == 0) ? GRAPH_NONNEG : (p == 1) ? GRAPH_MIXED : GRAPH_EXTREME;
      graph_phase(vc, inf_v, kind);
    end

    settle();
    repeat (16) @(posedge clk);
    @(negedge clk);
    if (errors == 0 && outstanding == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
